[sv/cau_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int QUO_BITS  = 34;          // quotient capped at 2^33
	localparam int DIV_STEPS = QUO_BITS;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic        is_div;
		logic        dbz;
		logic        sat;
		logic [31:0] fre;
		logic [31:0] fim;
		logic        nre;
		logic        nim;
		logic        ore;
		logic        oim;
		logic [63:0] den;
		logic [63:0] rre;
		logic [63:0] rim;
		logic [33:0] qre;
		logic [33:0] qim;
	} div_stage_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} clamp_t;

	// clamp a wide signed value to the 32-bit signed range
	function automatic clamp_t clamp65(input logic signed [64:0] v);
		clamp_t c;
		c.sat = 1'b0;
		c.val = v[31:0];
		if (v > 65'sh0_7FFF_FFFF) begin
			c.sat = 1'b1;
			c.val = 32'h7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			c.sat = 1'b1;
			c.val = 32'h8000_0000;
		end
		return c;
	endfunction

	// clamp a sign and quotient magnitude to the 32-bit signed range
	function automatic clamp_t clamp_quo(input logic neg, input logic [33:0] q);
		clamp_t c;
		c.sat = 1'b0;
		if (!neg) begin
			if (q > 34'h0_7FFF_FFFF) begin
				c.sat = 1'b1;
				c.val = 32'h7FFF_FFFF;
			end else begin
				c.val = q[31:0];
			end
		end else begin
			if (q > 34'h0_8000_0000) begin
				c.sat = 1'b1;
				c.val = 32'h8000_0000;
			end else begin
				c.val = 32'(-q);
			end
		end
		return c;
	endfunction

	// one restoring division step: bring in the next dividend bit, subtract if it fits
	function automatic logic [97:0] div_step(input logic [63:0] rem, input logic [33:0] quo,
			input logic [63:0] den);
		logic [63:0] r2;
		logic        qb;
		r2 = {rem[62:0], quo[33]};
		qb = (r2 >= den);
		if (qb) begin
			r2 = r2 - den;
		end
		return {r2, quo[32:0], qb};
	endfunction

endpackage

[sv/complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// Complex arithmetic unit top level: fully pipelined add, subtract, multiply, divide.
// Depends on cau_pkg.
//
// Takes one item per clock: busy is always low, so every cycle with start high
// accepts an item. Each item leaves as a one-cycle done strobe with
// result_real, result_imag, divide_by_zero and saturated; results leave in
// order and the receiver cannot stall them, so capture done when it fires.
// The pipeline has four stages of operand capture, multipliers, product sums
// and magnitude, one stage of divider setup, a 34-stage restoring divider with
// one quotient bit per stage, and one output stage. All operations travel the
// same path so order is kept. Operands are signed Q16.16; a scalar operand is
// given with zero imaginary part. Multiply rounds toward minus infinity, divide
// truncates toward zero, and any part out of 32-bit range is clamped with
// saturated set. A zero divisor returns zero with divide_by_zero set.
module complex_arithmetic_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_imag,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_imag,
	output logic        done,
	output logic signed [31:0] result_real,
	output logic signed [31:0] result_imag,
	output logic        divide_by_zero,
	output logic        saturated
);

	localparam int NDIV = cau_pkg::DIV_STEPS;

	// never stall: every stage advances every cycle
	assign busy = 1'b0;

	// stage 1: capture operands
	logic v_s1;
	logic [1:0] op_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= operation;
		ar_s1 <= a_real;
		ai_s1 <= a_imag;
		br_s1 <= b_real;
		bi_s1 <= b_imag;
	end

	// stage 2: all products in parallel, plus add/subtract sums
	logic v_s2;
	logic [1:0] op_s2;
	logic signed [63:0] prr_s2, pii_s2, pir_s2, pri_s2, pbr_s2, pbi_s2;
	logic signed [32:0] sre_s2, sim_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		prr_s2 <= ar_s1 * br_s1;
		pii_s2 <= ai_s1 * bi_s1;
		pir_s2 <= ai_s1 * br_s1;
		pri_s2 <= ar_s1 * bi_s1;
		pbr_s2 <= br_s1 * br_s1;
		pbi_s2 <= bi_s1 * bi_s1;
		if (op_s1 == cau_pkg::OP_SUB) begin
			sre_s2 <= {ar_s1[31], ar_s1} - {br_s1[31], br_s1};
			sim_s2 <= {ai_s1[31], ai_s1} - {bi_s1[31], bi_s1};
		end else begin
			sre_s2 <= {ar_s1[31], ar_s1} + {br_s1[31], br_s1};
			sim_s2 <= {ai_s1[31], ai_s1} + {bi_s1[31], bi_s1};
		end
	end

	// stage 3: combine products into exact wide real/imag sums and the divisor magnitude
	logic v_s3;
	logic [1:0] op_s3;
	logic signed [64:0] re_s3, im_s3;
	logic [63:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		den_s3 <= 64'(pbr_s2) + 64'(pbi_s2);
		case (op_s2)
			cau_pkg::OP_MUL: begin
				re_s3 <= {prr_s2[63], prr_s2} - {pii_s2[63], pii_s2};
				im_s3 <= {pir_s2[63], pir_s2} + {pri_s2[63], pri_s2};
			end
			cau_pkg::OP_DIV: begin
				re_s3 <= {prr_s2[63], prr_s2} + {pii_s2[63], pii_s2};
				im_s3 <= {pir_s2[63], pir_s2} - {pri_s2[63], pri_s2};
			end
			default: begin
				re_s3 <= 65'(sre_s2);
				im_s3 <= 65'(sim_s2);
			end
		endcase
	end

	// stage 4: finish add/sub/mul results, split divide numerators into sign and magnitude
	logic v_s4;
	logic is_div_s4, dbz_s4, sat_s4, nre_s4, nim_s4;
	logic [31:0] fre_s4, fim_s4;
	logic [63:0] mre_s4, mim_s4, den_s4;
	cau_pkg::clamp_t cre, cim;
	logic signed [64:0] sh_re, sh_im;

	always_comb begin
		sh_re = re_s3 >>> cau_pkg::FRAC_BITS;
		sh_im = im_s3 >>> cau_pkg::FRAC_BITS;
		if (op_s3 == cau_pkg::OP_MUL) begin
			cre = cau_pkg::clamp65(sh_re);
			cim = cau_pkg::clamp65(sh_im);
		end else begin
			cre = cau_pkg::clamp65(re_s3);
			cim = cau_pkg::clamp65(im_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		is_div_s4 <= (op_s3 == cau_pkg::OP_DIV);
		dbz_s4    <= (op_s3 == cau_pkg::OP_DIV) && (den_s3 == 64'd0);
		sat_s4    <= cre.sat | cim.sat;
		fre_s4    <= cre.val;
		fim_s4    <= cim.val;
		nre_s4    <= re_s3[64];
		nim_s4    <= im_s3[64];
		mre_s4    <= re_s3[64] ? 64'(-re_s3) : re_s3[63:0];
		mim_s4    <= im_s3[64] ? 64'(-im_s3) : im_s3[63:0];
		den_s4    <= den_s3;
	end

	// divider: entry 0 is setup (overflow check, initial remainder), 1..NDIV are bit steps
	logic                 div_v_sx [0:NDIV];
	cau_pkg::div_stage_t  div_sx   [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_sx[0] <= 1'b0;
		end else begin
			div_v_sx[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		div_sx[0].is_div <= is_div_s4;
		div_sx[0].dbz    <= dbz_s4;
		div_sx[0].sat    <= sat_s4;
		div_sx[0].fre    <= fre_s4;
		div_sx[0].fim    <= fim_s4;
		div_sx[0].nre    <= nre_s4;
		div_sx[0].nim    <= nim_s4;
		// quotient would reach 2^34 or more: cap it
		div_sx[0].ore    <= {18'd0, mre_s4} >= {den_s4, 18'd0};
		div_sx[0].oim    <= {18'd0, mim_s4} >= {den_s4, 18'd0};
		div_sx[0].den    <= den_s4;
		div_sx[0].rre    <= {18'd0, mre_s4[63:18]};
		div_sx[0].rim    <= {18'd0, mim_s4[63:18]};
		div_sx[0].qre    <= {mre_s4[17:0], 16'd0};
		div_sx[0].qim    <= {mim_s4[17:0], 16'd0};
	end

	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		logic [97:0] step_re, step_im;
		cau_pkg::div_stage_t nxt;

		assign step_re = cau_pkg::div_step(div_sx[k-1].rre, div_sx[k-1].qre, div_sx[k-1].den);
		assign step_im = cau_pkg::div_step(div_sx[k-1].rim, div_sx[k-1].qim, div_sx[k-1].den);

		always_comb begin
			nxt     = div_sx[k-1];
			nxt.rre = step_re[97:34];
			nxt.qre = step_re[33:0];
			nxt.rim = step_im[97:34];
			nxt.qim = step_im[33:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_sx[k] <= 1'b0;
			end else begin
				div_v_sx[k] <= div_v_sx[k-1];
			end
		end

		always_ff @(posedge clk) begin
			div_sx[k] <= nxt;
		end
	end

	// output stage: clamp quotients and pick the result for the operation
	cau_pkg::div_stage_t last;
	cau_pkg::clamp_t qre_c, qim_c;
	logic [33:0] qre_cap, qim_cap;

	assign last    = div_sx[NDIV];
	assign qre_cap = last.ore ? 34'h2_0000_0000 : last.qre;
	assign qim_cap = last.oim ? 34'h2_0000_0000 : last.qim;
	assign qre_c   = cau_pkg::clamp_quo(last.nre, qre_cap);
	assign qim_c   = cau_pkg::clamp_quo(last.nim, qim_cap);

	logic v_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else begin
			v_sf <= div_v_sx[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (!last.is_div) begin
			result_real    <= last.fre;
			result_imag    <= last.fim;
			saturated      <= last.sat;
			divide_by_zero <= 1'b0;
		end else if (last.dbz) begin
			result_real    <= '0;
			result_imag    <= '0;
			saturated      <= 1'b0;
			divide_by_zero <= 1'b1;
		end else begin
			result_real    <= qre_c.val;
			result_imag    <= qim_c.val;
			saturated      <= qre_c.sat | qim_c.sat;
			divide_by_zero <= 1'b0;
		end
	end

	assign done = v_sf;

	// checks
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n) start |-> ##40 done)
		else $error("accepted item did not complete after fixed latency");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> result_real == 32'd0 && result_imag == 32'd0 && !saturated)
		else $error("zero divisor result not cleared");

endmodule
